[src/bsls_pkg.sv]
// Package for the bounded sequence list store: operation, status and state codes,
// the command that steers the cell row, and default sizes.
// No dependencies.
package bsls_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Widest index and count that any legal capacity (up to 64) needs.
  localparam int IDX_MAX_W = 6;
  localparam int CNT_MAX_W = 7;

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_RM_FIRST   = 3'd1,
    OP_RM_LAST    = 3'd2,
    OP_RM_AT      = 3'd3,
    OP_READ_ALL   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_READ = 1'b1
  } fsm_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_ROTATE = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [IDX_MAX_W-1:0]   idx;
    logic [CNT_MAX_W-1:0]   count;
  } chain_cmd_t;

endpackage

[src/bsls_cell.sv]
// One cell of the list row: holds the entry at a fixed position.
// Depends on bsls_pkg for the row command.
module bsls_cell
  import bsls_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int POS        = 0
) (
  input  logic                  clk,
  input  chain_cmd_t            cmd,
  input  logic [DATA_WIDTH-1:0] append_val,
  input  logic [DATA_WIDTH-1:0] head_in,
  input  logic [DATA_WIDTH-1:0] next_in,
  output logic [DATA_WIDTH-1:0] data_out
);

  localparam logic [CNT_MAX_W-1:0] MY_POS = CNT_MAX_W'(POS);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic [CNT_MAX_W-1:0]  tail_pos;

  always_comb begin
    tail_pos = cmd.count - 1'b1;
    data_nxt = data_r;
    unique case (cmd.kind)
      CMD_APPEND: begin
        if (cmd.count == MY_POS) data_nxt = append_val;
      end
      CMD_REMOVE: begin
        // Everything from the removed slot onward moves one place toward the head.
        if (MY_POS >= CNT_MAX_W'(cmd.idx)) data_nxt = next_in;
      end
      CMD_ROTATE: begin
        if (MY_POS == tail_pos) data_nxt = head_in;
        else if (MY_POS < tail_pos) data_nxt = next_in;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

[src/bsls_chain.sv]
// Row of CAPACITY list cells, each handing its word to the cell before it.
// Depends on bsls_pkg and bsls_cell.
module bsls_chain
  import bsls_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  chain_cmd_t            cmd,
  input  logic [DATA_WIDTH-1:0] append_val,
  output logic [DATA_WIDTH-1:0] head_out,
  output logic [DATA_WIDTH-1:0] sel_out
);

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] nb;
    if (i == CAPACITY - 1) begin : g_end
      assign nb = cell_data[0];
    end else begin : g_mid
      assign nb = cell_data[i+1];
    end
    bsls_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .POS        (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .append_val (append_val),
      .head_in    (cell_data[0]),
      .next_in    (nb),
      .data_out   (cell_data[i])
    );
  end

  assign head_out = cell_data[0];

  // The word that a removal takes out, picked by a one-hot match on the index.
  always_comb begin
    sel_out = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.idx == IDX_MAX_W'(i)) sel_out = sel_out | cell_data[i];
    end
  end

endmodule

[src/bounded_sequence_list_store.sv]
// Top level of the bounded sequence list store: handshakes, operation decode,
// entry count and the output register. Depends on bsls_pkg and bsls_chain.
//
//   channel   | direction | tdata                                   | tuser       | tlast
//   in_       | input     | value[31:0], position[37:32]            | op[2:0]     | -
//   out_      | output    | item_value[31:0], entry_count[38:32]    | status[1:0] | last
//
// Append and the removals change the cell row in the cycle that accepts them.
// Read-all takes one cycle to accept, then rotates the row once per result, so it
// needs entry_count more cycles while the output is free, and leaves the row as it
// found it.
// A new item is taken while no read-all is under way and the output register is free or being emptied.
// A stalled output holds the cell row and the read-out where they are.
// Reset clears the entry count and the handshake state; the cells are not cleared.
module bounded_sequence_list_store
  import bsls_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], position[37:32], zero [39:38]
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // item_value[31:0], entry_count[38:32], zero [39]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

  fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] rd_cnt_r, rd_cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_val_r, out_val_nxt;
  status_t          out_st_r, out_st_nxt;
  logic [6:0]       out_cnt_r, out_cnt_nxt;
  logic             out_last_r, out_last_nxt;

  logic             slot_free;
  logic             in_fire;
  logic             emit;
  logic             take_sel;
  logic [31:0]      read_val;
  op_t              op;
  logic [5:0]       position;
  logic [CNT_MAX_W-1:0] pos_ext;
  logic [CNT_MAX_W-1:0] cnt_ext;
  logic signed [DATA_WIDTH-1:0] append_val;
  logic [DATA_WIDTH-1:0] head_data;
  logic [DATA_WIDTH-1:0] sel_data;
  chain_cmd_t       cmd;

  assign op         = op_t'(in_tuser);
  assign position   = in_tdata[37:32];
  assign pos_ext    = CNT_MAX_W'(position);
  assign cnt_ext    = CNT_MAX_W'(count_r);
  assign append_val = DATA_WIDTH'(signed'(in_tdata[31:0]));

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == FSM_IDLE) && slot_free;
  assign in_fire    = in_tvalid && in_tready;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    rd_cnt_nxt   = rd_cnt_r;
    emit         = 1'b0;
    take_sel     = 1'b0;
    read_val     = '0;
    out_st_nxt   = ST_OK;
    out_last_nxt = 1'b1;
    cmd.kind     = CMD_NONE;
    cmd.idx      = '0;
    cmd.count    = cnt_ext;

    unique case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          emit = 1'b1;
          unique case (op)
            OP_APPEND: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                out_st_nxt = ST_FULL;
              end else begin
                cmd.kind  = CMD_APPEND;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_RM_FIRST, OP_RM_LAST, OP_RM_AT: begin
              if (count_r == '0) begin
                out_st_nxt = ST_EMPTY;
              end else if (op == OP_RM_AT &&
                           (pos_ext == '0 || pos_ext > cnt_ext)) begin
                out_st_nxt = ST_BADPOS;
              end else begin
                cmd.kind = CMD_REMOVE;
                if (op == OP_RM_FIRST) cmd.idx = '0;
                else if (op == OP_RM_LAST) cmd.idx = IDX_MAX_W'(cnt_ext - 1'b1);
                else cmd.idx = IDX_MAX_W'(pos_ext - 1'b1);
                take_sel  = 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
            OP_READ_ALL: begin
              if (count_r == '0) begin
                out_st_nxt = ST_EMPTY;
              end else begin
                emit       = 1'b0;
                rd_cnt_nxt = '0;
                state_nxt  = FSM_READ;
              end
            end
            default: begin
              // Unused op codes leave the list alone and report the count.
              out_st_nxt = ST_OK;
            end
          endcase
        end
      end
      FSM_READ: begin
        if (slot_free) begin
          emit         = 1'b1;
          cmd.kind     = CMD_ROTATE;
          read_val     = 32'(signed'(head_data));
          out_last_nxt = (rd_cnt_r == IDX_W'(count_r - 1'b1));
          rd_cnt_nxt   = rd_cnt_r + 1'b1;
          if (out_last_nxt) state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase

    out_cnt_nxt = 7'(count_nxt);

    if (emit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // The removed word comes from the row after the index is decoded.
  assign out_val_nxt = take_sel ? 32'(signed'(sel_data)) : read_val;

  bsls_chain #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_chain (
    .clk        (clk),
    .cmd        (cmd),
    .append_val (append_val),
    .head_out   (head_data),
    .sel_out    (sel_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_val_r  <= out_val_nxt;
      out_st_r   <= out_st_nxt;
      out_cnt_r  <= out_cnt_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_val_r};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

endmodule
